// File: src/scan_point_to_cartesian_assert.svh
// Assertion macros used by the scan point conversion top level
`ifndef SCAN_POINT_TO_CARTESIAN_ASSERT_SVH
`define SCAN_POINT_TO_CARTESIAN_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define STP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define STP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/stp_pkg.sv
// Types, constants and helper functions for the scan point conversion block
package stp_pkg;

	localparam int ANGLE_BITS_DEF    = 16;
	localparam int DISTANCE_BITS_DEF = 16;

	localparam int PHASE_W     = 32;
	localparam int CORDIC_W    = 32;
	localparam int CORDIC_ITER = 16;
	localparam int ITER_IDX_W  = $clog2(CORDIC_ITER);
	localparam int TRIG_W      = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int OUT_W       = 18;

	localparam int OUT_MAX  = 131071;
	localparam int OUT_MIN  = -131072;
	localparam int TRIG_MAX = 32767;
	localparam int ROUND_HALF = 16384;
	localparam int FRAC_BITS  = 15;

	// two rotations per stage, then a rounding stage
	localparam int CORDIC_LAT = CORDIC_ITER / 2 + 1;
	localparam int CALC_LAT   = 4;
	localparam int LAT        = CORDIC_LAT + CALC_LAT;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sh26DD3B6A;

	// atan(2^-i) as a fraction of a turn, scaled by 2^32
	localparam logic signed [CORDIC_W-1:0] ATAN_TURN [CORDIC_ITER] = '{
		32'sh20000000, 32'sh12E4051D, 32'sh09FB385B, 32'sh051111D4,
		32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
		32'sh0028BE53, 32'sh00145F2E, 32'sh000A2F98, 32'sh000517CC,
		32'sh00028BE6, 32'sh000145F3, 32'sh0000A2F9, 32'sh0000517C
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HORIZONTAL_OFFSET = 2'd0,
		CFG_HEIGHT_OFFSET     = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic signed [CORDIC_W-1:0] z;
	} cordic_vec_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] c;
		logic signed [TRIG_W-1:0] s;
	} trig_t;

	// one CORDIC rotation; >>> is a floor shift on signed values
	function automatic cordic_vec_t cordic_rot(cordic_vec_t v, logic [ITER_IDX_W-1:0] i);
		cordic_vec_t r;
		logic signed [CORDIC_W-1:0] dx;
		logic signed [CORDIC_W-1:0] dy;
		dx = v.y >>> i;
		dy = v.x >>> i;
		if (!v.z[CORDIC_W-1]) begin
			r.x = v.x - dx;
			r.y = v.y + dy;
			r.z = v.z - ATAN_TURN[i];
		end else begin
			r.x = v.x + dx;
			r.y = v.y - dy;
			r.z = v.z + ATAN_TURN[i];
		end
		return r;
	endfunction

	// Q2.30 to Q1.15, round half up, clamp to +-TRIG_MAX
	function automatic logic signed [TRIG_W-1:0] round_clamp(logic signed [CORDIC_W-1:0] v);
		logic signed [CORDIC_W:0] t;
		t = ((CORDIC_W+1)'(v) + (CORDIC_W+1)'(ROUND_HALF)) >>> FRAC_BITS;
		if (t > (CORDIC_W+1)'(TRIG_MAX))
			return TRIG_W'(TRIG_MAX);
		else if (t < -(CORDIC_W+1)'(TRIG_MAX))
			return -TRIG_W'(TRIG_MAX);
		else
			return t[TRIG_W-1:0];
	endfunction

endpackage

// File: src/scan_point_to_cartesian.sv
// Top level: lidar sample (range, beam angle, rotator angle) to x, y, z point
// Datapath: two pipelined CORDICs in parallel, then a 4-stage multiply and round
// section.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and not taken, so in_ready = !out_valid || out_ready.
// Reset: arst_n clears the valid bits and both offset registers to zero.
module scan_point_to_cartesian #(
	parameter int ANGLE_BITS    = stp_pkg::ANGLE_BITS_DEF,
	parameter int DISTANCE_BITS = stp_pkg::DISTANCE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [DISTANCE_BITS-1:0]             distance,
	input  logic [ANGLE_BITS-1:0]                beam_angle,
	input  logic [ANGLE_BITS-1:0]                rotator_angle,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [stp_pkg::OUT_W-1:0]     point_x,
	output logic signed [stp_pkg::OUT_W-1:0]     point_y,
	output logic signed [stp_pkg::OUT_W-1:0]     point_z,
	input  logic                                 cfg_we,
	input  logic [stp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [stp_pkg::CFG_W-1:0]            cfg_data
);

`include "scan_point_to_cartesian_assert.svh"

	localparam int CLAT = stp_pkg::CORDIC_LAT;
	localparam int LAT  = stp_pkg::LAT;

	logic                               en;
	logic [LAT-1:0]                     vld_s;
	logic [DISTANCE_BITS-1:0]           dist_s [CLAT];
	logic signed [stp_pkg::CFG_W-1:0]   horizontal_offset_q;
	logic signed [stp_pkg::CFG_W-1:0]   height_offset_q;
	stp_pkg::trig_t                     beam_trig;
	stp_pkg::trig_t                     rot_trig;

	assign out_valid = vld_s[LAT-1];
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horizontal_offset_q <= '0;
			height_offset_q     <= '0;
		end else if (cfg_we) begin
			if (cfg_index == stp_pkg::CFG_HORIZONTAL_OFFSET)
				horizontal_offset_q <= cfg_data;
			else if (cfg_index == stp_pkg::CFG_HEIGHT_OFFSET)
				height_offset_q <= cfg_data;
		end
	end

	// range waits alongside the CORDICs
	always_ff @(posedge clk) begin
		if (en) begin
			dist_s[0] <= distance;
			for (int i = 1; i < CLAT; i++)
				dist_s[i] <= dist_s[i-1];
		end
	end

	stp_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_beam_cordic (
		.clk   (clk),
		.en    (en),
		.angle (beam_angle),
		.trig  (beam_trig)
	);

	stp_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_rot_cordic (
		.clk   (clk),
		.en    (en),
		.angle (rotator_angle),
		.trig  (rot_trig)
	);

	stp_calc #(.DISTANCE_BITS(DISTANCE_BITS)) u_calc (
		.clk               (clk),
		.en                (en),
		.distance          (dist_s[CLAT-1]),
		.beam              (beam_trig),
		.rot               (rot_trig),
		.horizontal_offset (horizontal_offset_q),
		.height_offset     (height_offset_q),
		.point_x           (point_x),
		.point_y           (point_y),
		.point_z           (point_z)
	);

	`STP_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_s), "pipeline moved while stalled")
	`STP_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_s[0],
		"accepted item missing from first stage")
	`STP_ASSERT_NEXT(a_cfg_write, cfg_we && cfg_index == stp_pkg::CFG_HORIZONTAL_OFFSET,
		horizontal_offset_q == $past(cfg_data), "horizontal offset write lost")

endmodule

// File: src/stp_cordic.sv
// Pipelined CORDIC giving Q1.15 cosine and sine of a fractional-turn angle
module stp_cordic #(
	parameter int ANGLE_BITS = stp_pkg::ANGLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [ANGLE_BITS-1:0] angle,
	output stp_pkg::trig_t        trig
);

	localparam int STAGES = stp_pkg::CORDIC_ITER / 2;

	logic [stp_pkg::PHASE_W-1:0] phase;
	stp_pkg::cordic_vec_t        vec_in;
	stp_pkg::cordic_vec_t        vec_s  [STAGES];
	logic [1:0]                  quad_s [STAGES];
	stp_pkg::trig_t              trig_s9;
	logic signed [stp_pkg::TRIG_W-1:0] c_r;
	logic signed [stp_pkg::TRIG_W-1:0] s_r;

	assign phase    = {angle, {(stp_pkg::PHASE_W-ANGLE_BITS){1'b0}}};
	assign vec_in.x = stp_pkg::CORDIC_GAIN;
	assign vec_in.y = '0;
	assign vec_in.z = {2'b00, phase[stp_pkg::PHASE_W-3:0]};

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		stp_pkg::cordic_vec_t src;
		stp_pkg::cordic_vec_t mid;
		stp_pkg::cordic_vec_t nxt;
		logic [1:0]           quad_src;

		if (k == 0) begin : g_first
			assign src      = vec_in;
			assign quad_src = phase[stp_pkg::PHASE_W-1 -: 2];
		end else begin : g_rest
			assign src      = vec_s[k-1];
			assign quad_src = quad_s[k-1];
		end

		always_comb begin
			mid = stp_pkg::cordic_rot(src, stp_pkg::ITER_IDX_W'(2 * k));
			nxt = stp_pkg::cordic_rot(mid, stp_pkg::ITER_IDX_W'(2 * k + 1));
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[k]  <= nxt;
				quad_s[k] <= quad_src;
			end
		end
	end

	assign c_r = stp_pkg::round_clamp(vec_s[STAGES-1].x);
	assign s_r = stp_pkg::round_clamp(vec_s[STAGES-1].y);

	// fold the first-quadrant result out to the full turn
	always_ff @(posedge clk) begin
		if (en) begin
			unique case (quad_s[STAGES-1])
				2'd0: begin
					trig_s9.c <= c_r;
					trig_s9.s <= s_r;
				end
				2'd1: begin
					trig_s9.c <= -s_r;
					trig_s9.s <= c_r;
				end
				2'd2: begin
					trig_s9.c <= -c_r;
					trig_s9.s <= -s_r;
				end
				2'd3: begin
					trig_s9.c <= s_r;
					trig_s9.s <= -c_r;
				end
			endcase
		end
	end

	assign trig = trig_s9;

endmodule

// File: src/stp_calc.sv
// Beam plane point and rotator turn: multiply, offset, round and saturate
module stp_calc #(
	parameter int DISTANCE_BITS = stp_pkg::DISTANCE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [DISTANCE_BITS-1:0]          distance,
	input  stp_pkg::trig_t                    beam,
	input  stp_pkg::trig_t                    rot,
	input  logic signed [stp_pkg::CFG_W-1:0]  horizontal_offset,
	input  logic signed [stp_pkg::CFG_W-1:0]  height_offset,
	output logic signed [stp_pkg::OUT_W-1:0]  point_x,
	output logic signed [stp_pkg::OUT_W-1:0]  point_y,
	output logic signed [stp_pkg::OUT_W-1:0]  point_z
);

	localparam int TW     = stp_pkg::TRIG_W;
	localparam int PROD_W = DISTANCE_BITS + TW + 1;
	localparam int SUM_W  = (PROD_W > 32 ? PROD_W : 32) + 2;
	localparam int R_W    = SUM_W - stp_pkg::FRAC_BITS;
	localparam int P_W    = R_W + TW;
	localparam int PS_W   = P_W + 1;

	logic signed [DISTANCE_BITS:0] d_ext;

	logic signed [PROD_W-1:0] pb_s1;
	logic signed [PROD_W-1:0] ps_s1;
	logic signed [TW-1:0]     ct_s1;
	logic signed [TW-1:0]     st_s1;

	logic signed [SUM_W-1:0]  r_sum;
	logic signed [SUM_W-1:0]  z_sum;
	logic signed [R_W-1:0]    r_s2;
	logic signed [R_W-1:0]    z_s2;
	logic signed [TW-1:0]     ct_s2;
	logic signed [TW-1:0]     st_s2;

	logic signed [P_W-1:0]    px_s3;
	logic signed [P_W-1:0]    py_s3;
	logic signed [R_W-1:0]    z_s3;

	logic signed [PS_W-1:0]   x_rnd;
	logic signed [PS_W-1:0]   y_rnd;
	logic signed [stp_pkg::OUT_W-1:0] x_sat;
	logic signed [stp_pkg::OUT_W-1:0] y_sat;
	logic signed [stp_pkg::OUT_W-1:0] z_sat;
	logic signed [stp_pkg::OUT_W-1:0] point_x_s4;
	logic signed [stp_pkg::OUT_W-1:0] point_y_s4;
	logic signed [stp_pkg::OUT_W-1:0] point_z_s4;

	assign d_ext = signed'({1'b0, distance});

	always_ff @(posedge clk) begin
		if (en) begin
			pb_s1 <= PROD_W'(d_ext * beam.c);
			ps_s1 <= PROD_W'(d_ext * beam.s);
			ct_s1 <= rot.c;
			st_s1 <= rot.s;
		end
	end

	// r = -d*cos(a) + h, z = d*sin(a) + v, both rounded half up
	always_comb begin
		r_sum = (-SUM_W'(pb_s1) + (SUM_W'(horizontal_offset) <<< stp_pkg::FRAC_BITS)
			+ SUM_W'(stp_pkg::ROUND_HALF)) >>> stp_pkg::FRAC_BITS;
		z_sum = (SUM_W'(ps_s1) + (SUM_W'(height_offset) <<< stp_pkg::FRAC_BITS)
			+ SUM_W'(stp_pkg::ROUND_HALF)) >>> stp_pkg::FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2  <= r_sum[R_W-1:0];
			z_s2  <= z_sum[R_W-1:0];
			ct_s2 <= ct_s1;
			st_s2 <= st_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s3 <= P_W'(r_s2 * ct_s2);
			py_s3 <= P_W'(r_s2 * st_s2);
			z_s3  <= z_s2;
		end
	end

	always_comb begin
		x_rnd = (PS_W'(px_s3) + PS_W'(stp_pkg::ROUND_HALF)) >>> stp_pkg::FRAC_BITS;
		y_rnd = (-PS_W'(py_s3) + PS_W'(stp_pkg::ROUND_HALF)) >>> stp_pkg::FRAC_BITS;

		if (x_rnd > PS_W'(stp_pkg::OUT_MAX))
			x_sat = stp_pkg::OUT_W'(stp_pkg::OUT_MAX);
		else if (x_rnd < PS_W'(stp_pkg::OUT_MIN))
			x_sat = stp_pkg::OUT_W'(stp_pkg::OUT_MIN);
		else
			x_sat = x_rnd[stp_pkg::OUT_W-1:0];

		if (y_rnd > PS_W'(stp_pkg::OUT_MAX))
			y_sat = stp_pkg::OUT_W'(stp_pkg::OUT_MAX);
		else if (y_rnd < PS_W'(stp_pkg::OUT_MIN))
			y_sat = stp_pkg::OUT_W'(stp_pkg::OUT_MIN);
		else
			y_sat = y_rnd[stp_pkg::OUT_W-1:0];

		if (z_s3 > R_W'(stp_pkg::OUT_MAX))
			z_sat = stp_pkg::OUT_W'(stp_pkg::OUT_MAX);
		else if (z_s3 < R_W'(stp_pkg::OUT_MIN))
			z_sat = stp_pkg::OUT_W'(stp_pkg::OUT_MIN);
		else
			z_sat = z_s3[stp_pkg::OUT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			point_x_s4 <= x_sat;
			point_y_s4 <= y_sat;
			point_z_s4 <= z_sat;
		end
	end

	assign point_x = point_x_s4;
	assign point_y = point_y_s4;
	assign point_z = point_z_s4;

endmodule

// File: dv/scan_point_to_cartesian_tb_check.sv
// Point checker: watches both channels and the register port, predicts each point, compares
`timescale 1ns / 1ps

module scan_point_to_cartesian_tb_check #(
	parameter int ANGLE_BITS    = stp_pkg::ANGLE_BITS_DEF,
	parameter int DISTANCE_BITS = stp_pkg::DISTANCE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [DISTANCE_BITS-1:0]           distance,
	input  logic [ANGLE_BITS-1:0]              beam_angle,
	input  logic [ANGLE_BITS-1:0]              rotator_angle,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic signed [stp_pkg::OUT_W-1:0]   point_x,
	input  logic signed [stp_pkg::OUT_W-1:0]   point_y,
	input  logic signed [stp_pkg::OUT_W-1:0]   point_z,
	input  logic                               cfg_we,
	input  logic [stp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [stp_pkg::CFG_W-1:0]          cfg_data,
	output int                                 mismatches,
	output int                                 points_owed,
	output int                                 points_seen
);

	typedef struct packed {
		logic signed [stp_pkg::OUT_W-1:0] x;
		logic signed [stp_pkg::OUT_W-1:0] y;
		logic signed [stp_pkg::OUT_W-1:0] z;
	} point_t;

	point_t expected_points [$];
	longint horiz_off = 0;
	longint vert_off = 0;
	int     fault_total = 0;
	int     owed_q = 0;
	int     seen_total = 0;

	assign mismatches  = fault_total;
	assign points_owed = owed_q;
	assign points_seen = seen_total;

	// arctangent of 2^-i as a fraction of a turn, scaled by 2^32
	function automatic longint atan_step(int i);
		case (i)
			0:  return 64'sh20000000;
			1:  return 64'sh12E4051D;
			2:  return 64'sh09FB385B;
			3:  return 64'sh051111D4;
			4:  return 64'sh028B0D43;
			5:  return 64'sh0145D7E1;
			6:  return 64'sh00A2F61E;
			7:  return 64'sh00517C55;
			8:  return 64'sh0028BE53;
			9:  return 64'sh00145F2E;
			10: return 64'sh000A2F98;
			11: return 64'sh000517CC;
			12: return 64'sh00028BE6;
			13: return 64'sh000145F3;
			14: return 64'sh0000A2F9;
			15: return 64'sh0000517C;
			default: return 64'sd0;
		endcase
	endfunction

	// add half, floor shift by 15
	function automatic longint round_q15(longint v);
		return (v + 64'sd16384) >>> 15;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// cos and sin of an angle in turns, Q1.15
	function automatic void turn_trig(input logic [ANGLE_BITS-1:0] angle,
			output longint c, output longint s);
		logic [31:0] phase;
		longint x, y, z, dx, dy, cq, sq;
		int i;
		phase = 32'(angle) << (32 - ANGLE_BITS);
		z = longint'({34'd0, phase[29:0]});
		x = 64'sd652032874;
		y = 0;
		for (i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - atan_step(i);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + atan_step(i);
			end
		end
		cq = clip(round_q15(x), -stp_pkg::TRIG_MAX, stp_pkg::TRIG_MAX);
		sq = clip(round_q15(y), -stp_pkg::TRIG_MAX, stp_pkg::TRIG_MAX);
		case (phase[31:30])
			2'd0: begin c = cq;  s = sq;  end
			2'd1: begin c = -sq; s = cq;  end
			2'd2: begin c = -cq; s = -sq; end
			default: begin c = sq; s = -cq; end
		endcase
	endfunction

	function automatic point_t predict_point(logic [DISTANCE_BITS-1:0] d,
			logic [ANGLE_BITS-1:0] beam, logic [ANGLE_BITS-1:0] rot,
			longint h_off, longint v_off);
		longint cb, sb, ct, st, dl, r, zp;
		point_t p;
		turn_trig(beam, cb, sb);
		turn_trig(rot, ct, st);
		dl = longint'(d);
		// planar point in the beam plane, then turned by the rotator
		r  = round_q15(h_off * 32768 - dl * cb);
		zp = round_q15(dl * sb + v_off * 32768);
		p.x = stp_pkg::OUT_W'(clip(round_q15(r * ct),
			stp_pkg::OUT_MIN, stp_pkg::OUT_MAX));
		p.y = stp_pkg::OUT_W'(clip(round_q15(-(r * st)),
			stp_pkg::OUT_MIN, stp_pkg::OUT_MAX));
		p.z = stp_pkg::OUT_W'(clip(zp, stp_pkg::OUT_MIN, stp_pkg::OUT_MAX));
		return p;
	endfunction

	// one line per mismatch
	task automatic report_mismatch(input string what);
		fault_total++;
		$display("%0t ns mismatch: %s", $time, what);
	endtask

	task automatic compare_field(input string field,
			input logic signed [stp_pkg::OUT_W-1:0] got,
			input logic signed [stp_pkg::OUT_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("point %0d %s = %0d, expected %0d",
				seen_total, field, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		point_t want;
		if (!arst_n) begin
			expected_points.delete();
			horiz_off = 0;
			vert_off  = 0;
			owed_q   <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_points.push_back(predict_point(distance, beam_angle,
					rotator_angle, horiz_off, vert_off));
			if (cfg_we) begin
				case (stp_pkg::cfg_reg_t'(cfg_index))
					stp_pkg::CFG_HORIZONTAL_OFFSET:
						horiz_off = longint'($signed(cfg_data));
					stp_pkg::CFG_HEIGHT_OFFSET:
						vert_off  = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					report_mismatch($sformatf("unexpected point (%0d, %0d, %0d)",
						point_x, point_y, point_z));
				end else begin
					want = expected_points.pop_front();
					compare_field("x", point_x, want.x);
					compare_field("y", point_y, want.y);
					compare_field("z", point_z, want.z);
				end
				seen_total++;
			end
			owed_q <= expected_points.size();
		end
	end

endmodule

// File: dv/scan_point_to_cartesian_tb.sv
// Testbench top: drives samples and offset writes into the scan point converter
`timescale 1ns / 1ps

module scan_point_to_cartesian_tb;

	localparam int RUN_LIMIT     = 200000;
	localparam int RANDOM_POINTS = 1400;
	localparam int SETTINGS_N    = 6;

	// register indexes with nothing behind them
	localparam logic [stp_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [stp_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   in_valid = 1'b0;
	logic                                   in_ready;
	logic [stp_pkg::DISTANCE_BITS_DEF-1:0]  distance = '0;
	logic [stp_pkg::ANGLE_BITS_DEF-1:0]     beam_angle = '0;
	logic [stp_pkg::ANGLE_BITS_DEF-1:0]     rotator_angle = '0;
	logic                                   out_valid;
	logic                                   out_ready = 1'b0;
	logic signed [stp_pkg::OUT_W-1:0]       point_x;
	logic signed [stp_pkg::OUT_W-1:0]       point_y;
	logic signed [stp_pkg::OUT_W-1:0]       point_z;
	logic                                   cfg_we = 1'b0;
	logic [stp_pkg::CFG_IDX_W-1:0]          cfg_index = '0;
	logic [stp_pkg::CFG_W-1:0]              cfg_data = '0;

	int mismatches;
	int points_owed;
	int points_seen;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycles = 0;
	int drains = 0;

	scan_point_to_cartesian uut (.*);

	scan_point_to_cartesian_tb_check point_check (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	task automatic send_point(input logic [stp_pkg::DISTANCE_BITS_DEF-1:0] d,
			input logic [stp_pkg::ANGLE_BITS_DEF-1:0] b,
			input logic [stp_pkg::ANGLE_BITS_DEF-1:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		distance      <= d;
		beam_angle    <= b;
		rotator_angle <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// hold the sender off until every point owed has come out
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (points_owed != 0);
		drains++;
	endtask

	task automatic write_regs(input logic [stp_pkg::CFG_IDX_W-1:0] ia,
			input logic [stp_pkg::CFG_W-1:0] da,
			input logic [stp_pkg::CFG_IDX_W-1:0] ib,
			input logic [stp_pkg::CFG_W-1:0] db);
		cfg_we    <= 1'b1;
		cfg_index <= ia;
		cfg_data  <= da;
		@(posedge clk);
		cfg_index <= ib;
		cfg_data  <= db;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// a quarter of angles sit within two steps of a quadrant boundary
	function automatic logic [stp_pkg::ANGLE_BITS_DEF-1:0] random_angle();
		if ($urandom_range(3) == 0)
			return (16'($urandom_range(3)) << 14) + 16'($urandom_range(4)) - 16'd2;
		return 16'($urandom);
	endfunction

	task automatic random_point();
		logic [stp_pkg::DISTANCE_BITS_DEF-1:0] d;
		if ($urandom_range(7) == 0)
			d = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		else
			d = 16'($urandom);
		send_point(d, random_angle(), random_angle());
	endtask

	initial begin : stimulus
		int k;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 16;
		recv_idle_pct = 51;

		// directed: reset offsets, quadrant edges, full range, zero range
		send_point(16'h0000, 16'h0000, 16'h0000);
		send_point(16'hFFFF, 16'h0000, 16'h0000);
		send_point(16'hFFFF, 16'h4000, 16'h0000);
		send_point(16'hFFFF, 16'h8000, 16'h0000);
		send_point(16'hFFFF, 16'hC000, 16'h0000);
		send_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_point(16'hFFFF, 16'h0000, 16'h4000);
		send_point(16'hFFFF, 16'h0000, 16'h8000);
		send_point(16'hFFFF, 16'h0000, 16'hC000);
		send_point(16'hFFFF, 16'h2000, 16'h2000);
		send_point(16'hFFFF, 16'h0001, 16'h0001);
		send_point(16'hFFFF, 16'h7FFF, 16'h8001);
		send_point(16'h0001, 16'h3FFF, 16'hC001);
		send_point(16'hFFFF, 16'h6000, 16'hE000);
		send_point(16'h0000, 16'hFFFF, 16'h8000);
		send_point(16'hAAAA, 16'h5555, 16'hAAAA);
		send_point(16'h5555, 16'hAAAA, 16'h5555);
		send_point(16'hFFFF, 16'h1000, 16'hF000);
		send_point(16'h8000, 16'hBFFF, 16'h4001);
		send_point(16'h7FFF, 16'h8000, 16'h7FFF);

		for (k = 0; k < SETTINGS_N; k++) begin
			pause_until_drained();
			case (k)
				0: write_regs(stp_pkg::CFG_HORIZONTAL_OFFSET, 16'h7FFF,
					stp_pkg::CFG_HEIGHT_OFFSET, 16'h7FFF);
				1: write_regs(stp_pkg::CFG_HORIZONTAL_OFFSET, 16'h8000,
					stp_pkg::CFG_HEIGHT_OFFSET, 16'h8000);
				2: write_regs(stp_pkg::CFG_HORIZONTAL_OFFSET, 16'h7FFF,
					stp_pkg::CFG_HEIGHT_OFFSET, 16'h8000);
				3: write_regs(stp_pkg::CFG_HORIZONTAL_OFFSET, 16'h8000,
					stp_pkg::CFG_HEIGHT_OFFSET, 16'h7FFF);
				4: write_regs(stp_pkg::CFG_HORIZONTAL_OFFSET, 16'($urandom),
					stp_pkg::CFG_HEIGHT_OFFSET, 16'($urandom));
				default: write_regs(stp_pkg::CFG_HORIZONTAL_OFFSET, 16'hFFFF,
					stp_pkg::CFG_HEIGHT_OFFSET, 16'h0001);
			endcase
			// writes to unused indexes must leave the offsets alone
			if (k == 0)
				write_regs(CFG_SPARE_LO, 16'hFFFF, CFG_SPARE_HI, 16'h8000);
			case (k / 2)
				0: begin send_idle_pct = 16; recv_idle_pct = 51; end
				1: begin send_idle_pct = 51; recv_idle_pct = 16; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			repeat (RANDOM_POINTS / SETTINGS_N) begin
				if ($urandom_range(199) == 0)
					pause_until_drained();
				random_point();
			end
		end

		pause_until_drained();
		repeat (stp_pkg::LAT + 4) @(posedge clk);

		$display("Checked %0d points across six offset settings, offsets at both extremes,",
			points_seen);
		$display("quadrant edges and full-range distances; %0d pipeline drains.", drains);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
